// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the stepper block checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside of reset.
`define SSG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clk edge, reset included.
`define SSG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/ssg_pkg.sv =====
// ----------------------------------------------------------------------------
// ssg_pkg
// Types and constants shared by the stepper step generator modules.
// ----------------------------------------------------------------------------
package ssg_pkg;

  // Default sizes of the tick counter and of the step position counter.
  localparam int PERIOD_BITS_DEF   = 20;
  localparam int POSITION_BITS_DEF = 16;

  // Fixed field widths.
  localparam int OUT_POS_W = 16;

  // Register reset values.
  localparam logic [15:0] MAX_SPEED_RST    = 16'd4000;
  localparam logic [15:0] HOMING_SPEED_RST = 16'd2000;
  localparam logic [14:0] HALF_RANGE_RST   = 15'd889;
  localparam logic [7:0]  DEBOUNCE_RST     = 8'd5;

  // Item opcodes.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_CMD  = 1'b1;

  // Period divider: 1e8 / (max_speed * pct) or 1e6 / homing_speed.
  localparam int DIV_DIVIDEND_W = 27;
  localparam int DIV_DIVISOR_W  = 23;
  localparam int DIV_CNT_W      = $clog2(DIV_DIVIDEND_W);
  localparam logic [DIV_DIVIDEND_W-1:0] CMD_DIVIDEND  = DIV_DIVIDEND_W'(100000000);
  localparam logic [DIV_DIVIDEND_W-1:0] HOME_DIVIDEND = DIV_DIVIDEND_W'(1000000);
  localparam logic [DIV_CNT_W-1:0]      DIV_LAST      = DIV_CNT_W'(DIV_DIVIDEND_W - 1);

  // Product of max_speed and percentage below which the motor stops.
  localparam logic [DIV_DIVISOR_W-1:0] PROD_STOP_LIMIT = DIV_DIVISOR_W'(100);
  localparam logic signed [7:0] PCT_LIMIT = 8'sd100;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_MAX_SPEED,
    REG_HOMING_SPEED,
    REG_HALF_RANGE,
    REG_DEBOUNCE
  } reg_idx_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic apply;       // accepted item updates the motor state
    logic div_run;     // divider takes one quotient bit
    logic div_finish;  // last divider step, load the new period
  } ctl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_req;     // applied item needs a new period
  } ctl_sts_t;

endpackage

// ===== rtl/core/ssg_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssg_ctrl
// Handshake and sequencing controller: accepts items, holds the result
// valid flag and steps the period divider.
// ----------------------------------------------------------------------------
module ssg_ctrl
  import ssg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ctl_cmd_t cmd,
  input  ctl_sts_t sts
);

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 accept;

  // An item enters when idle and the result slot is free or being emptied.
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // Next state and commands.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r;
    cmd.apply      = accept;
    cmd.div_run    = 1'b0;
    cmd.div_finish = 1'b0;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept && sts.div_req) begin
          state_nxt = ST_DIV;
          cnt_nxt   = DIV_LAST;
        end
      end
      ST_DIV: begin
        cmd.div_run = 1'b1;
        if (cnt_r == '0) begin
          cmd.div_finish = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/ssg_dpath.sv =====
// ----------------------------------------------------------------------------
// ssg_dpath
// Motor state datapath: tick counter, step toggling, position count,
// homing and debounce logic, period divider and result register.
// ----------------------------------------------------------------------------
module ssg_dpath
  import ssg_pkg::*;
#(
  parameter int PERIOD_BITS   = PERIOD_BITS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_cmd_t              cmd,
  output ctl_sts_t              sts,
  input  logic [15:0]           max_speed,
  input  logic [15:0]           homing_speed,
  input  logic [14:0]           half_range_steps,
  input  logic [7:0]            debounce_limit,
  input  logic                  in_opcode,
  input  logic                  in_hall_level,
  input  logic signed [7:0]     in_speed_pct,
  input  logic                  in_episode_end,
  output logic                  out_step_level,
  output logic                  out_dir_level,
  output logic signed [15:0]    out_position_steps,
  output logic                  out_episode_done,
  output logic                  out_is_homing,
  output logic                  out_is_running
);

  localparam int CW = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 1;
  localparam int SW = (PERIOD_BITS > DIV_DIVIDEND_W) ? PERIOD_BITS : DIV_DIVIDEND_W;
  localparam logic signed [POSITION_BITS-1:0] POS_MAX = {1'b0, {(POSITION_BITS-1){1'b1}}};
  localparam logic signed [POSITION_BITS-1:0] POS_MIN = {1'b1, {(POSITION_BITS-1){1'b0}}};
  localparam logic signed [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
  localparam logic [SW-1:0] PERIOD_MAX = SW'({PERIOD_BITS{1'b1}});

  // Motor state.
  logic                            running_r, running_nxt;
  logic                            step_r, step_nxt;
  logic                            dir_r, dir_nxt;
  logic signed [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic                            homing_r, homing_nxt;
  logic                            done_r, done_nxt;
  logic                            center_r, center_nxt;
  logic [7:0]                      deb_r, deb_nxt;
  logic [PERIOD_BITS-1:0]          count_r, count_nxt;
  logic [PERIOD_BITS-1:0]          reload_r;

  // Divider state.
  logic [DIV_DIVIDEND_W-1:0] quo_r, quo_step;
  logic [DIV_DIVISOR_W-1:0]  rem_r, rem_step, divisor_r;
  logic [DIV_DIVISOR_W:0]    trial;
  logic [SW-1:0]             quo_ext;

  // Command operands.
  logic signed [7:0]        pct_clip;
  logic [6:0]               pct_mag;
  logic [DIV_DIVISOR_W-1:0] prod;
  logic [PERIOD_BITS:0]     count_plus;
  logic signed [CW-1:0]     pos_w, half_w;
  logic                     home_req, div_home;
  logic [OUT_POS_W-1:0]     pos_out_nxt;

  // Clip the percentage and form max_speed times its magnitude.
  assign pct_clip = (in_speed_pct > PCT_LIMIT)  ? PCT_LIMIT :
                    (in_speed_pct < -PCT_LIMIT) ? -PCT_LIMIT : in_speed_pct;
  assign pct_mag  = (pct_clip < 0) ? 7'(-pct_clip) : 7'(pct_clip);
  assign prod     = DIV_DIVISOR_W'(max_speed) * DIV_DIVISOR_W'(pct_mag);

  assign count_plus = {1'b0, count_r} + 1'b1;
  assign half_w     = CW'(signed'({1'b0, half_range_steps}));

  // Item update of the motor state.
  always_comb begin
    running_nxt = running_r;
    step_nxt    = step_r;
    dir_nxt     = dir_r;
    pos_nxt     = pos_r;
    homing_nxt  = homing_r;
    done_nxt    = done_r;
    center_nxt  = center_r;
    deb_nxt     = deb_r;
    count_nxt   = count_r;
    home_req    = 1'b0;
    div_home    = 1'b0;
    sts.div_req = 1'b0;
    pos_w       = '0;
    if (cmd.apply) begin
      if (in_opcode == OP_CMD) begin
        // Speed command, ignored once the episode is done.
        if (!done_r) begin
          if (in_episode_end) begin
            done_nxt = 1'b1;
            home_req = 1'b1;
          end else begin
            if (pct_clip < 0) begin
              dir_nxt = 1'b0;
            end else if (pct_clip > 0) begin
              dir_nxt = 1'b1;
            end
            if (prod < PROD_STOP_LIMIT) begin
              running_nxt = 1'b0;
              step_nxt    = 1'b0;
              count_nxt   = '0;
            end else begin
              running_nxt = 1'b1;
              sts.div_req = 1'b1;
            end
            done_nxt = 1'b0;
          end
        end
      end else if (running_r) begin
        // Microsecond tick while running.
        if (count_plus >= {1'b0, reload_r}) begin
          count_nxt = '0;
          step_nxt  = !step_r;
          if (in_hall_level) begin
            pos_nxt = '0;
          end
          if (step_nxt) begin
            if (dir_r) begin
              if (pos_nxt != POS_MAX) begin
                pos_nxt = pos_nxt + POS_ONE;
              end
            end else begin
              if (pos_nxt != POS_MIN) begin
                pos_nxt = pos_nxt - POS_ONE;
              end
            end
            pos_w = CW'(pos_nxt);
            if (!homing_r) begin
              if (!done_r && (pos_w >= half_w || pos_w <= -half_w)) begin
                done_nxt = 1'b1;
                home_req = 1'b1;
              end else begin
                done_nxt = 1'b0;
              end
            end else begin
              // Debounce of the hall sensor while homing.
              if (in_hall_level && !center_r) begin
                center_nxt = 1'b1;
                deb_nxt    = '0;
              end else if (in_hall_level && center_r) begin
                if (deb_r != 8'hFF) begin
                  deb_nxt = deb_r + 1'b1;
                end
              end else if (!in_hall_level && center_r && deb_r > debounce_limit) begin
                center_nxt  = 1'b0;
                deb_nxt     = '0;
                homing_nxt  = 1'b0;
                done_nxt    = 1'b0;
                pos_nxt     = '0;
                running_nxt = 1'b0;
                step_nxt    = 1'b0;
                count_nxt   = '0;
              end
            end
          end
        end else begin
          count_nxt = count_plus[PERIOD_BITS-1:0];
        end
      end
      // Start of homing toward zero.
      if (home_req) begin
        homing_nxt = 1'b1;
        if (pos_nxt > 0) begin
          dir_nxt = 1'b0;
        end else if (pos_nxt < 0) begin
          dir_nxt = 1'b1;
        end
        if (pos_nxt == 0) begin
          homing_nxt  = 1'b0;
          done_nxt    = 1'b0;
          running_nxt = 1'b0;
          step_nxt    = 1'b0;
          count_nxt   = '0;
        end else if (homing_speed == '0) begin
          running_nxt = 1'b0;
          step_nxt    = 1'b0;
          count_nxt   = '0;
        end else begin
          running_nxt = 1'b1;
          sts.div_req = 1'b1;
          div_home    = 1'b1;
        end
      end
    end
  end

  // One restoring divider step per cycle.
  assign trial    = {rem_r, quo_r[DIV_DIVIDEND_W-1]};
  assign rem_step = (trial >= {1'b0, divisor_r}) ?
                    DIV_DIVISOR_W'(trial - {1'b0, divisor_r}) : trial[DIV_DIVISOR_W-1:0];
  assign quo_step = {quo_r[DIV_DIVIDEND_W-2:0], (trial >= {1'b0, divisor_r})};
  assign quo_ext  = SW'(quo_step);

  // Result position is the low bits of the count, sign extended if narrower.
  generate
    if (POSITION_BITS >= OUT_POS_W) begin : g_pos_trunc
      assign pos_out_nxt = pos_nxt[OUT_POS_W-1:0];
    end else begin : g_pos_ext
      assign pos_out_nxt = {{(OUT_POS_W-POSITION_BITS){pos_nxt[POSITION_BITS-1]}}, pos_nxt};
    end
  endgenerate

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      step_r    <= 1'b0;
      dir_r     <= 1'b0;
      pos_r     <= '0;
      homing_r  <= 1'b0;
      done_r    <= 1'b0;
      center_r  <= 1'b0;
      deb_r     <= '0;
      count_r   <= '0;
      reload_r  <= '0;
    end else begin
      running_r <= running_nxt;
      step_r    <= step_nxt;
      dir_r     <= dir_nxt;
      pos_r     <= pos_nxt;
      homing_r  <= homing_nxt;
      done_r    <= done_nxt;
      center_r  <= center_nxt;
      deb_r     <= deb_nxt;
      count_r   <= count_nxt;
      if (cmd.div_finish) begin
        reload_r <= (quo_ext > PERIOD_MAX) ? {PERIOD_BITS{1'b1}} : PERIOD_BITS'(quo_ext);
      end
    end
  end

  // Divider operands and result register.
  always_ff @(posedge clk) begin
    if (sts.div_req) begin
      quo_r     <= div_home ? HOME_DIVIDEND : CMD_DIVIDEND;
      divisor_r <= div_home ? DIV_DIVISOR_W'(homing_speed) : prod;
      rem_r     <= '0;
    end else if (cmd.div_run) begin
      quo_r <= quo_step;
      rem_r <= rem_step;
    end
    if (cmd.apply) begin
      out_step_level     <= step_nxt;
      out_dir_level      <= dir_nxt;
      out_position_steps <= signed'(pos_out_nxt);
      out_episode_done   <= done_nxt;
      out_is_homing      <= homing_nxt;
      out_is_running     <= running_nxt;
    end
  end

endmodule

// ===== rtl/core/stepper_step_generator_with_homing.sv =====
// ----------------------------------------------------------------------------
// stepper_step_generator_with_homing
// Step and direction generator with range limit and hall sensor homing.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one item per microsecond
// tick (opcode tick, with the sampled hall level) or a speed command (signed
// percentage and episode-end flag). Every item yields exactly one result item
// on the output channel (out_valid/out_ready): step and direction levels,
// the saturating step count and the done, homing and running flags after
// that item.
// A result is registered and appears in the cycle after its item is accepted.
// Ticks and commands that set no new period skip the divider. An item that
// loads a new toggle period (a speed command, or the start of homing) runs a
// one bit per cycle restoring divider, which keeps in_ready low until its last
// quotient bit. A result that the receiver has not taken stays in the output
// register; the next item is accepted no earlier than the cycle that result is
// taken. After reset the motor is stopped at count zero and the registers hold
// their defaults (4000, 2000, 889, 5). Registers are to be written through the
// APB port while no item is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module stepper_step_generator_with_homing
  import ssg_pkg::*;
#(
  parameter int PERIOD_BITS   = PERIOD_BITS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic               in_hall_level,
  input  logic signed [7:0]  in_speed_pct,
  input  logic               in_episode_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_step_level,
  output logic               out_dir_level,
  output logic signed [15:0] out_position_steps,
  output logic               out_episode_done,
  output logic               out_is_homing,
  output logic               out_is_running,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [15:0] max_speed_r;
  logic [15:0] homing_speed_r;
  logic [14:0] half_range_r;
  logic [7:0]  debounce_r;
  reg_idx_t    reg_idx;
  ctl_cmd_t    cmd;
  ctl_sts_t    sts;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r    <= MAX_SPEED_RST;
      homing_speed_r <= HOMING_SPEED_RST;
      half_range_r   <= HALF_RANGE_RST;
      debounce_r     <= DEBOUNCE_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_MAX_SPEED:    max_speed_r    <= pwdata[15:0];
        REG_HOMING_SPEED: homing_speed_r <= pwdata[15:0];
        REG_HALF_RANGE:   half_range_r   <= pwdata[14:0];
        REG_DEBOUNCE:     debounce_r     <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Configuration register reads.
  always_comb begin
    case (reg_idx)
      REG_MAX_SPEED:    prdata = 32'(max_speed_r);
      REG_HOMING_SPEED: prdata = 32'(homing_speed_r);
      REG_HALF_RANGE:   prdata = 32'(half_range_r);
      REG_DEBOUNCE:     prdata = 32'(debounce_r);
      default:          prdata = '0;
    endcase
  end

  ssg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ssg_dpath #(
    .PERIOD_BITS   (PERIOD_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .max_speed          (max_speed_r),
    .homing_speed       (homing_speed_r),
    .half_range_steps   (half_range_r),
    .debounce_limit     (debounce_r),
    .in_opcode          (in_opcode),
    .in_hall_level      (in_hall_level),
    .in_speed_pct       (in_speed_pct),
    .in_episode_end     (in_episode_end),
    .out_step_level     (out_step_level),
    .out_dir_level      (out_dir_level),
    .out_position_steps (out_position_steps),
    .out_episode_done   (out_episode_done),
    .out_is_homing      (out_is_homing),
    .out_is_running     (out_is_running)
  );

endmodule

// ===== rtl/core/ssg_chk.sv =====
// ----------------------------------------------------------------------------
// ssg_chk
// Port level checker for the stepper step generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssg_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_step_level,
  input logic signed [15:0] out_position_steps,
  input logic        out_episode_done,
  input logic        out_is_homing,
  input logic        out_is_running
);

  // A result that is not taken holds its position.
  `SSG_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_position_steps), "stalled result changed")

  // No item is taken while an untaken result waits.
  `SSG_ASSERT(a_no_overrun, out_valid && !out_ready |-> !in_ready, "item accepted over a waiting result")

  // A stopped motor leaves the step pin low.
  `SSG_ASSERT(a_stop_low, out_valid && !out_is_running |-> !out_step_level, "step level high while stopped")

  // Homing only happens within a finished episode.
  `SSG_ASSERT(a_home_done, out_valid && out_is_homing |-> out_episode_done, "homing without episode done")

  // Reset empties the result slot.
  `SSG_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind stepper_step_generator_with_homing ssg_chk u_chk (.*);
